>>> rtl/srm_pkg.sv
`timescale 1ns / 1ps
// Shared types, character codes and the atom test for the regex matcher.
// Depends on nothing; every other file of the matcher uses it.
package srm_pkg;

   localparam int MaxPatternDefault = 32;

   typedef enum logic [1:0] {
      ACT_CLEAR  = 2'd0,
      ACT_APPEND = 2'd1,
      ACT_TEXT   = 2'd2,
      ACT_END    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      KIND_LIT   = 2'd0,
      KIND_ANY   = 2'd1,
      KIND_DIGIT = 2'd2,
      KIND_WORD  = 2'd3
   } atom_kind_type;

   typedef enum logic [2:0] {
      PS_START  = 3'b001,
      PS_ATOM   = 3'b010,
      PS_BSLASH = 3'b100
   } parse_state_type;

   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_D      = 8'h64;
   localparam logic [7:0] CH_W      = 8'h77;
   localparam logic [7:0] CH_0      = 8'h30;
   localparam logic [7:0] CH_9      = 8'h39;
   localparam logic [7:0] CH_LA     = 8'h61;
   localparam logic [7:0] CH_LZ     = 8'h7A;
   localparam logic [7:0] CH_UA     = 8'h41;
   localparam logic [7:0] CH_UZ     = 8'h5A;

   // Edits that the pattern parser makes to the atom cells.
   typedef struct packed {
      logic          load;
      logic          set_star;
      logic          set_class;
      atom_kind_type kind;
      logic [7:0]    chr;
   } atom_wr_type;

   // Per-word control broadcast along the cell chain.
   typedef struct packed {
      logic       step;
      logic       restart;
      logic [7:0] chr;
   } cell_ctl_type;

   function automatic logic atom_accepts(atom_kind_type kind, logic [7:0] atom_chr,
                                         logic [7:0] c);
      logic ok;
      unique case (kind)
         KIND_ANY:   ok = 1'b1;
         KIND_DIGIT: ok = (c >= CH_0) && (c <= CH_9);
         KIND_WORD:  ok = ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ));
         default:    ok = (c == atom_chr);
      endcase
      return ok;
   endfunction

endpackage

>>> rtl/srm_parse.sv
`timescale 1ns / 1ps
// Incremental pattern parser: turns appended pattern bytes into atom edits.
// Depends on srm_pkg.
module srm_parse #(
   parameter int MAX_PATTERN = srm_pkg::MaxPatternDefault,
   localparam int CNT_W = $clog2(MAX_PATTERN + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                clear,
   input  logic                append,
   input  logic [7:0]          chr,
   output srm_pkg::atom_wr_type atom_wr,
   output logic [CNT_W-1:0]    atom_count,
   output logic [CNT_W-1:0]    live_count,
   output logic                anchor_start,
   output logic                anchor_end,
   output logic                overflow
);

   logic [CNT_W-1:0]         length_ff, length_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   srm_pkg::parse_state_type state_ff, state_in;
   logic                     anc_start_ff, anc_start_in;
   logic                     dollar_ff, dollar_in;
   logic                     overflow_ff, overflow_in;
   logic                     new_atom;

   always_comb begin
      length_in    = length_ff;
      count_in     = count_ff;
      state_in     = state_ff;
      anc_start_in = anc_start_ff;
      dollar_in    = dollar_ff;
      overflow_in  = overflow_ff;
      new_atom     = 1'b0;
      atom_wr      = '0;
      atom_wr.chr  = chr;
      atom_wr.kind = (chr == srm_pkg::CH_DOT) ? srm_pkg::KIND_ANY : srm_pkg::KIND_LIT;
      if (clear) begin
         length_in    = '0;
         count_in     = '0;
         state_in     = srm_pkg::PS_START;
         anc_start_in = 1'b0;
         dollar_in    = 1'b0;
         overflow_in  = 1'b0;
      end else if (append) begin
         if (length_ff == CNT_W'(MAX_PATTERN)) begin
            overflow_in = 1'b1;
         end else begin
            length_in = length_ff + 1'b1;
            if ((length_ff == '0) && (chr == srm_pkg::CH_CARET)) begin
               anc_start_in = 1'b1;
            end else begin
               unique case (state_ff)
                  srm_pkg::PS_ATOM: begin
                     if (chr == srm_pkg::CH_STAR) begin
                        atom_wr.set_star = 1'b1;
                        state_in         = srm_pkg::PS_START;
                        dollar_in        = 1'b0;
                     end else begin
                        new_atom = 1'b1;
                     end
                  end
                  srm_pkg::PS_BSLASH: begin
                     // The previous atom is a backslash; d or w turns it into a class.
                     if ((chr == srm_pkg::CH_D) || (chr == srm_pkg::CH_W)) begin
                        atom_wr.set_class = 1'b1;
                        atom_wr.kind      = (chr == srm_pkg::CH_D) ? srm_pkg::KIND_DIGIT
                                                                   : srm_pkg::KIND_WORD;
                        state_in          = srm_pkg::PS_ATOM;
                     end else if (chr == srm_pkg::CH_STAR) begin
                        atom_wr.set_star = 1'b1;
                        state_in         = srm_pkg::PS_START;
                     end else begin
                        new_atom = 1'b1;
                     end
                  end
                  default: begin
                     new_atom = 1'b1;
                  end
               endcase
               if (new_atom) begin
                  atom_wr.load = 1'b1;
                  count_in     = count_ff + 1'b1;
                  state_in     = (chr == srm_pkg::CH_BSLASH) ? srm_pkg::PS_BSLASH
                                                             : srm_pkg::PS_ATOM;
                  // A dollar is an end anchor only while it remains the last byte.
                  dollar_in    = (chr == srm_pkg::CH_DOLLAR);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff    <= '0;
         count_ff     <= '0;
         state_ff     <= srm_pkg::PS_START;
         anc_start_ff <= 1'b0;
         dollar_ff    <= 1'b0;
         overflow_ff  <= 1'b0;
      end else begin
         length_ff    <= length_in;
         count_ff     <= count_in;
         state_ff     <= state_in;
         anc_start_ff <= anc_start_in;
         dollar_ff    <= dollar_in;
         overflow_ff  <= overflow_in;
      end
   end

   assign atom_count   = count_ff;
   assign live_count   = count_ff - CNT_W'(dollar_ff);
   assign anchor_start = anc_start_ff;
   assign anchor_end   = dollar_ff;
   assign overflow     = overflow_ff;

endmodule

>>> rtl/srm_cell.sv
`timescale 1ns / 1ps
// One NFA cell: holds one atom and the position bit in front of it.
// Depends on srm_pkg.
module srm_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  srm_pkg::atom_wr_type atom_wr,
   input  logic [CNT_W-1:0]     atom_count,
   input  logic [CNT_W-1:0]     live_count,
   input  srm_pkg::cell_ctl_type ctl,
   input  logic                 eps_in,
   input  logic                 step_in,
   output logic                 eps_out,
   output logic                 step_out,
   output logic                 closed,
   output logic                 active
);

   srm_pkg::atom_kind_type kind_ff;
   logic [7:0]             chr_ff;
   logic                   star_ff;
   logic                   active_ff, active_in;
   logic                   live;
   logic                   hit;
   logic                   sel_new;
   logic                   sel_last;

   assign sel_new  = (atom_count == CNT_W'(INDEX));
   assign sel_last = (atom_count == CNT_W'(INDEX + 1));
   assign live     = (CNT_W'(INDEX) < live_count);

   // Closure arrives from the left neighbour through a starred atom.
   assign closed   = active_ff | eps_in;
   assign hit      = live & closed & srm_pkg::atom_accepts(kind_ff, chr_ff, ctl.chr);
   assign eps_out  = live & closed & star_ff;
   assign step_out = hit & ~star_ff;
   assign active   = active_ff;

   always_comb begin
      active_in = active_ff;
      if (ctl.restart) begin
         active_in = (INDEX == 0);
      end else if (ctl.step) begin
         active_in = (hit & star_ff) | step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= (INDEX == 0);
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (atom_wr.load && sel_new) begin
         kind_ff <= atom_wr.kind;
         chr_ff  <= atom_wr.chr;
         star_ff <= 1'b0;
      end else begin
         if (atom_wr.set_star && sel_last) begin
            star_ff <= 1'b1;
         end
         if (atom_wr.set_class && sel_last) begin
            kind_ff <= atom_wr.kind;
         end
      end
   end

endmodule

>>> rtl/simple_regex_matcher_unit.sv
`timescale 1ns / 1ps
// Throughput: one word per cycle, but an end-of-text word waits while an unread
// result word is held; the position vector of the cell chain advances one text
// byte per cycle, with closure rippling through the cells in that cycle.
// Reset is synchronous and active high: empty pattern, no overflow, start position.
// Depends on srm_pkg, srm_parse and srm_cell.
module simple_regex_matcher_unit #(
   parameter int MAX_PATTERN = srm_pkg::MaxPatternDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_action,
   input  logic [7:0] req_pattern_char,
   input  logic [7:0] req_text_char,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_matched,
   output logic       rsp_pattern_overflow
);

   localparam int CNT_W = $clog2(MAX_PATTERN + 1);
   localparam int POS_N = MAX_PATTERN + 1;
   localparam logic [POS_N-1:0] ALL_ONES = '1;

   srm_pkg::action_type   action;
   logic                  fire;
   srm_pkg::atom_wr_type  atom_wr;
   srm_pkg::cell_ctl_type ctl;
   logic [CNT_W-1:0]      atom_count;
   logic [CNT_W-1:0]      live_count;
   logic                  anchor_start;
   logic                  anchor_end;
   logic                  overflow;
   logic [POS_N-1:0]      eps;
   logic [POS_N-1:0]      step;
   logic [POS_N-1:0]      closed_vec;
   logic [POS_N-1:0]      pos_vec;
   logic                  pos_last_ff, pos_last_in;
   logic                  match_seen_ff, match_seen_in;
   logic                  match_now;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_matched_ff;
   logic                  rsp_overflow_ff;

   assign action    = srm_pkg::action_type'(req_action);
   // Only an end-of-text word needs the result register to be free.
   assign req_ready = ~rsp_valid_ff | rsp_ready | (action != srm_pkg::ACT_END);
   assign fire      = req_valid & req_ready;

   assign ctl.step    = fire & (action == srm_pkg::ACT_TEXT);
   assign ctl.restart = fire & (action != srm_pkg::ACT_TEXT);
   assign ctl.chr     = req_text_char;

   srm_parse #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_parse (
      .clock        (clock),
      .reset        (reset),
      .clear        (fire & (action == srm_pkg::ACT_CLEAR)),
      .append       (fire & (action == srm_pkg::ACT_APPEND)),
      .chr          (req_pattern_char),
      .atom_wr      (atom_wr),
      .atom_count   (atom_count),
      .live_count   (live_count),
      .anchor_start (anchor_start),
      .anchor_end   (anchor_end),
      .overflow     (overflow)
   );

   assign eps[0]  = 1'b0;
   assign step[0] = ~anchor_start;

   for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
      if (k < MAX_PATTERN - 1) begin : g_inner
         srm_cell #(
            .INDEX (k),
            .CNT_W (CNT_W)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .atom_wr    (atom_wr),
            .atom_count (atom_count),
            .live_count (live_count),
            .ctl        (ctl),
            .eps_in     (eps[k]),
            .step_in    (step[k]),
            .eps_out    (eps[k+1]),
            .step_out   (step[k+1]),
            .closed     (closed_vec[k]),
            .active     (pos_vec[k])
         );
      end else begin : g_tail
         srm_cell #(
            .INDEX (k),
            .CNT_W (CNT_W)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .atom_wr    (atom_wr),
            .atom_count (atom_count),
            .live_count (live_count),
            .ctl        (ctl),
            .eps_in     (eps[k]),
            .step_in    (step[k]),
            .eps_out    (eps[MAX_PATTERN]),
            .step_out   (step[MAX_PATTERN]),
            .closed     (closed_vec[k]),
            .active     (pos_vec[k])
         );
      end
   end

   // The final position sits after the last cell and only ever accepts.
   assign closed_vec[MAX_PATTERN] = pos_last_ff | eps[MAX_PATTERN];
   assign pos_vec[MAX_PATTERN]    = pos_last_ff;
   assign match_now               = closed_vec[live_count];

   always_comb begin
      pos_last_in   = pos_last_ff;
      match_seen_in = match_seen_ff;
      if (ctl.restart) begin
         pos_last_in   = 1'b0;
         match_seen_in = 1'b0;
      end else if (ctl.step) begin
         pos_last_in   = step[MAX_PATTERN];
         match_seen_in = match_seen_ff | (~anchor_end & match_now);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire && (action == srm_pkg::ACT_END)) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_last_ff   <= 1'b0;
         match_seen_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pos_last_ff   <= pos_last_in;
         match_seen_ff <= match_seen_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && (action == srm_pkg::ACT_END)) begin
         rsp_matched_ff  <= match_now | (~anchor_end & match_seen_ff);
         rsp_overflow_ff <= overflow;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_matched          = rsp_matched_ff;
   assign rsp_pattern_overflow = rsp_overflow_ff;

   // Any word other than a text byte leaves only the start position and no match.
   a_restart : assert property (@(posedge clock) disable iff (reset)
      ctl.restart |=> (pos_vec == POS_N'(1)) && !match_seen_ff)
      else $error("text state not restarted");

   // A result word is only raised by an end-of-text word.
   a_rsp_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(fire && (action == srm_pkg::ACT_END)))
      else $error("result word without end of text");

   // No position lies beyond the accepting position of the live pattern.
   a_pos_bound : assert property (@(posedge clock) disable iff (reset)
      (pos_vec & ((ALL_ONES << live_count) << 1)) == '0)
      else $error("active position beyond the pattern");

   // The live atom count never exceeds the stored atom count.
   a_live_count : assert property (@(posedge clock) disable iff (reset)
      live_count <= atom_count)
      else $error("live atom count out of range");

endmodule
